[sv/largest_prime_scan_defines.svh]
// assertion macros shared by the largest prime scan rtl
// no dependencies; included by files that carry concurrent checks
`ifndef LARGEST_PRIME_SCAN_DEFINES_SVH
`define LARGEST_PRIME_SCAN_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lps same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define LPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lps next-cycle check failed");

`endif

[sv/lps_pkg.sv]
// shared types and constants for the largest prime scan block
// no dependencies; used by the interfaces, the top level and the testbench
`default_nettype none

package lps_pkg;

   // width of the reported prime
   localparam int OUT_WIDTH = 31;

   // smallest trial divisor
   localparam int FIRST_DIVISOR = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_EVAL,
      ST_FINISH
   } state_type;

   // control from the sequencer to the datapath
   typedef struct packed {
      logic req_ready;
      logic div_start;
      logic set_first;
      logic next_divisor;
      logic mark_prime;
      logic mark_composite;
      logic commit;
      logic out_load;
   } ctrl_type;

endpackage

`default_nettype wire

[sv/lps_if.sv]
// valid/ready channel interfaces for the largest prime scan block
// depends on lps_pkg for the result width
`default_nettype none

interface lps_req_if #(
   parameter int DATA_WIDTH = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] value;
   logic                         last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface lps_rsp_if ();
   logic                             valid;
   logic                             ready;
   logic [lps_pkg::OUT_WIDTH-1:0]    largest_prime;
   logic                             found;

   modport source (output valid, output largest_prime, output found, input ready);
   modport sink   (input valid, input largest_prime, input found, output ready);
endinterface

`default_nettype wire

[sv/largest_prime_scan.sv]
// largest prime scan top level: trial-division sequencer around a shared divider
// depends on lps_pkg, lps_if (lps_req_if, lps_rsp_if), lps_div and the defines header
//
//   channel   dir  payload                      transfer when
//   req_if    in   value, last                  valid && ready
//   rsp_if    out  largest_prime, found         valid && ready
//
// one element at a time; req_if.ready is high only while idle.
// per element: accept and screen, then one run of the divider for each trial
// divisor d = 2, 3, ... up to the first d that divides or has d*d > value, then commit.
// worst case at DATA_WIDTH = 32 is 46340 trial divisors.
// a final element holds in the commit cycle until the result register is free.
// reset is synchronous and clears the sequencer, the running maximum and rsp valid.
// a held result does not block the next element until that element's own result is due.
`default_nettype none
`include "largest_prime_scan_defines.svh"

module largest_prime_scan #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lps_req_if.sink    req_if,
   lps_rsp_if.source  rsp_if
);

   localparam int W     = DATA_WIDTH - 1;
   localparam int OUT_W = lps_pkg::OUT_WIDTH;

   lps_pkg::state_type state_ff, state_in;
   lps_pkg::ctrl_type  ctrl;

   logic [W-1:0]     cand_ff, cand_in;
   logic             neg_ff, neg_in;
   logic             last_ff, last_in;
   logic [W-1:0]     d_ff, d_in;
   logic             prime_ff, prime_in;
   logic [W-1:0]     best_ff, best_in;
   logic             any_ff, any_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] largest_ff, largest_in;
   logic             found_ff, found_in;

   logic             div_done;
   logic [W-1:0]     div_q;
   logic [W-1:0]     div_r;
   logic             trivial;
   logic             beyond_root;
   logic             divides;
   logic             out_free;
   logic             upd;
   logic [W-1:0]     new_best;
   logic             new_any;

   lps_div #(
      .WIDTH (W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (ctrl.div_start),
      .dividend  (cand_ff),
      .divisor   (ctrl.set_first ? W'(lps_pkg::FIRST_DIVISOR) : d_ff + W'(1)),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // negative, zero and one are never prime
   assign trivial     = neg_ff || (cand_ff[W-1:1] == '0);
   assign beyond_root = d_ff > div_q;
   assign divides     = (div_r == '0);
   assign out_free    = !rsp_valid_ff || rsp_if.ready;

   assign upd      = prime_ff && (!any_ff || cand_ff > best_ff);
   assign new_best = upd ? cand_ff : best_ff;
   assign new_any  = any_ff || prime_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lps_pkg::ST_IDLE: begin
            if (req_if.valid) state_in = lps_pkg::ST_CHECK;
         end
         lps_pkg::ST_CHECK: begin
            state_in = trivial ? lps_pkg::ST_FINISH : lps_pkg::ST_DIV;
         end
         lps_pkg::ST_DIV: begin
            if (div_done) state_in = lps_pkg::ST_EVAL;
         end
         lps_pkg::ST_EVAL: begin
            state_in = (beyond_root || divides) ? lps_pkg::ST_FINISH : lps_pkg::ST_DIV;
         end
         lps_pkg::ST_FINISH: begin
            if (!last_ff || out_free) state_in = lps_pkg::ST_IDLE;
         end
         default: state_in = lps_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         lps_pkg::ST_IDLE: begin
            ctrl.req_ready = 1'b1;
         end
         lps_pkg::ST_CHECK: begin
            ctrl.mark_composite = trivial;
            ctrl.div_start      = !trivial;
            ctrl.set_first      = !trivial;
         end
         lps_pkg::ST_DIV: begin
            ctrl = '0;
         end
         lps_pkg::ST_EVAL: begin
            ctrl.mark_prime     = beyond_root;
            ctrl.mark_composite = !beyond_root && divides;
            ctrl.next_divisor   = !beyond_root && !divides;
            ctrl.div_start      = !beyond_root && !divides;
         end
         lps_pkg::ST_FINISH: begin
            ctrl.commit   = !last_ff || out_free;
            ctrl.out_load = last_ff && out_free;
         end
         default: ctrl = '0;
      endcase
   end

   // datapath next values
   always_comb begin
      cand_in = cand_ff;
      neg_in  = neg_ff;
      last_in = last_ff;
      if (ctrl.req_ready && req_if.valid) begin
         cand_in = req_if.value[W-1:0];
         neg_in  = req_if.value[W];
         last_in = req_if.last;
      end

      d_in = d_ff;
      if (ctrl.set_first)    d_in = W'(lps_pkg::FIRST_DIVISOR);
      if (ctrl.next_divisor) d_in = d_ff + W'(1);

      prime_in = prime_ff;
      if (ctrl.mark_prime)     prime_in = 1'b1;
      if (ctrl.mark_composite) prime_in = 1'b0;

      best_in = best_ff;
      any_in  = any_ff;
      if (ctrl.commit) begin
         if (last_ff) begin
            best_in = '0;
            any_in  = 1'b0;
         end else begin
            best_in = new_best;
            any_in  = new_any;
         end
      end

      largest_in   = largest_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (ctrl.out_load) begin
         largest_in   = new_any ? OUT_W'(new_best) : '0;
         found_in     = new_any;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff    <= cand_in;
      neg_ff     <= neg_in;
      last_ff    <= last_in;
      d_ff       <= d_in;
      prime_ff   <= prime_in;
      largest_ff <= largest_in;
      found_ff   <= found_in;
      if (reset) begin
         state_ff     <= lps_pkg::ST_IDLE;
         best_ff      <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         best_ff      <= best_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_if.ready         = ctrl.req_ready;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.largest_prime = largest_ff;
   assign rsp_if.found         = found_ff;

   `LPS_ASSERT_NOW(a_done_in_div, clock, reset, div_done, state_ff == lps_pkg::ST_DIV)
   `LPS_ASSERT_NEXT(a_accept_to_check, clock, reset, req_if.valid && req_if.ready, state_ff == lps_pkg::ST_CHECK)
   `LPS_ASSERT_NOW(a_empty_best_zero, clock, reset, !any_ff, best_ff == '0)
   `LPS_ASSERT_NOW(a_not_found_zero, clock, reset, rsp_valid_ff && !found_ff, largest_ff == '0)
   `LPS_ASSERT_NOW(a_divisor_min, clock, reset, state_ff == lps_pkg::ST_EVAL, d_ff >= W'(lps_pkg::FIRST_DIVISOR))

endmodule

`default_nettype wire

[sv/lps_div.sv]
// restoring divider, one quotient bit per cycle, quotient and remainder registered
// no package dependencies
`default_nettype none

module lps_div #(
   parameter int WIDTH = 31
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  done,
   output logic [WIDTH-1:0]      quotient,
   output logic [WIDTH-1:0]      remainder
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;

   always_comb begin
      trial   = {rem_ff, acc_ff[WIDTH-1]} - {1'b0, dsr_ff};
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift the next dividend bit in, keep the difference when it fits
         if (!trial[WIDTH]) begin
            rem_in = trial[WIDTH-1:0];
            acc_in = {acc_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[WIDTH-2:0], acc_ff[WIDTH-1]};
            acc_in = {acc_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = acc_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

[bench/largest_prime_scan_tb.sv]
// testbench for largest_prime_scan: streams matrices of signed elements and checks each
// reported largest prime against a trial-division predictor kept in the bench
// depends on lps_pkg and the lps_req_if / lps_rsp_if interfaces of the rtl
`timescale 1ns / 100ps

module largest_prime_scan_tb;

   localparam int DATA_WIDTH  = 32;
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int SETTLE_CYCLES = 200;

   typedef struct packed {
      logic [lps_pkg::OUT_WIDTH-1:0] largest_prime;
      logic                          found;
   } scan_result_type;

   logic clock;
   logic reset;

   lps_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
   lps_rsp_if rsp_ch ();

   largest_prime_scan #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // predictor state
   logic [DATA_WIDTH-1:0] best_so_far;
   logic                  prime_seen;
   scan_result_type       pending_scans[$];

   int fail_count  = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // compare every result transfer with the oldest prediction
   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_scans.size() == 0) begin
            $display("%0t: unexpected result, largest_prime %0d found %0b",
                     $time, rsp_ch.largest_prime, rsp_ch.found);
            fail_count++;
         end else begin
            want = pending_scans.pop_front();
            if (rsp_ch.largest_prime !== want.largest_prime) begin
               $display("%0t: largest_prime mismatch, expected %0d actual %0d",
                        $time, want.largest_prime, rsp_ch.largest_prime);
               fail_count++;
            end
            if (rsp_ch.found !== want.found) begin
               $display("%0t: found mismatch, expected %0b actual %0b",
                        $time, want.found, rsp_ch.found);
               fail_count++;
            end
         end
      end
   end

   function automatic bit is_prime_value(input longint unsigned v);
      longint unsigned d;
      if (v < 2) return 1'b0;
      for (d = 2; d <= v / d; d++) begin
         if (v % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // fold one element into the running maximum; a final element closes the scan
   function automatic void absorb_element(input logic signed [DATA_WIDTH-1:0] v,
                                          input logic fin);
      scan_result_type res;
      logic [DATA_WIDTH-1:0] mag;
      mag = v;
      if (!mag[DATA_WIDTH-1] && is_prime_value(longint'(mag))) begin
         if (!prime_seen || mag > best_so_far) begin
            best_so_far = mag;
            prime_seen  = 1'b1;
         end
      end
      if (fin) begin
         res.largest_prime = prime_seen ? best_so_far[lps_pkg::OUT_WIDTH-1:0] : '0;
         res.found         = prime_seen;
         pending_scans.push_back(res);
         best_so_far = '0;
         prime_seen  = 1'b0;
      end
   endfunction

   // mostly small magnitudes keep the trial division short
   function automatic logic signed [DATA_WIDTH-1:0] pick_element();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return $urandom_range(0, 2000);
      else if (sel < 65) return {1'b1, 31'($urandom)};
      else if (sel < 77) return $urandom & 32'h7FFF_FFFE;
      else if (sel < 87) return $urandom_range(1, 715827882) * 3;
      else return $urandom_range(2001, 200000);
   endfunction

   task automatic send_element(input logic signed [DATA_WIDTH-1:0] v, input logic fin);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      req_ch.last  <= fin;
      do @(posedge clock); while (!req_ch.ready);
      absorb_element(v, fin);
   endtask

   task automatic drop_request();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_scans.size() != 0) @(posedge clock);
   endtask

   task automatic test_edge_values();
      // nothing prime: zero, one, negatives down to the most negative value
      send_element(0, 1'b0);
      send_element(1, 1'b0);
      send_element(-1, 1'b0);
      send_element(32'sh8000_0000, 1'b1);
      // single-element matrix holding the smallest prime
      send_element(2, 1'b1);
      // the largest positive value is itself prime (the long trial run)
      send_element(3, 1'b0);
      send_element(4, 1'b0);
      send_element(9, 1'b0);
      send_element(25, 1'b0);
      send_element(32'sh7FFF_FFFE, 1'b0);
      send_element(32'sh7FFF_FFFF, 1'b1);
      // smaller primes after a larger one must not replace it
      send_element(97, 1'b0);
      send_element(13, 1'b0);
      send_element(100, 1'b0);
      send_element(89, 1'b1);
      // no primes: state must have cleared after the previous transfer
      send_element(49, 1'b0);
      send_element(1, 1'b0);
      send_element(0, 1'b1);
      // final element is the largest prime
      send_element(5, 1'b0);
      send_element(121, 1'b0);
      send_element(11, 1'b1);
      send_element(-7, 1'b0);
      send_element(6, 1'b1);
   endtask

   task automatic test_drain_pause();
      send_element(17, 1'b0);
      send_element(20, 1'b0);
      send_element(13, 1'b1);
      drop_request();
      wait_drained();
      send_element(19, 1'b1);
   endtask

   task automatic test_random_matrices(input int n_items, input int s_idle, input int r_idle);
      int sent;
      int len;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            send_element(pick_element(), i == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      req_ch.last  = 1'b0;
      rsp_ch.ready = 1'b0;
      best_so_far  = '0;
      prime_seen   = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      recv_idle_pct = 65;
      test_edge_values();
      test_drain_pause();
      test_random_matrices(25, 30, 65);
      test_random_matrices(25, 65, 30);
      test_random_matrices(25, 0, 0);
      drop_request();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
